// File: hdl/pwg_pkg.sv
// Package for the periodic waveform generator.
// Holds sizes, register and mode codes, the pipeline word type and the quarter-wave sine ROM.
// No dependencies.
package pwg_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int SINE_DEPTH  = 1024;
	localparam int MOD_CELLS   = 33;
	localparam int FRAC_CELLS  = FRAC_BITS;
	localparam int TOTAL_CELLS = MOD_CELLS + FRAC_CELLS;
	localparam int IDX_BITS    = $clog2(4 * SINE_DEPTH);
	localparam int ROM_AW      = $clog2(SINE_DEPTH + 1);

	typedef longint unsigned u64_t;

	localparam u64_t Q30_ONE = 64'd1073741824;
	localparam u64_t COEF1   = 64'd1686629713;
	localparam u64_t COEF3   = 64'd693598669;
	localparam u64_t COEF5   = 64'd85569306;
	localparam u64_t COEF7   = 64'd5026995;
	localparam u64_t COEF9   = 64'd172272;

	typedef enum logic [2:0] {
		REG_WAVE_MODE    = 3'd0,
		REG_AMPLITUDE    = 3'd1,
		REG_LEVEL_OFFSET = 3'd2,
		REG_PHASE_SHIFT  = 3'd3,
		REG_PERIOD_TICKS = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		WAVE_HALF_SINE = 3'd0,
		WAVE_SINE      = 3'd1,
		WAVE_SQUARE    = 3'd2,
		WAVE_SAW       = 3'd3,
		WAVE_TRIANGLE  = 3'd4
	} wave_mode_t;

	typedef struct packed {
		logic                 valid;
		logic [31:0]          rem;
		logic [32:0]          num;
		logic [FRAC_BITS-1:0] quo;
		logic                 sq;
	} div_word_t;

	typedef logic [15:0] rom_t [SINE_DEPTH+1];

	function automatic rom_t sine_rom_f();
		rom_t t;
		u64_t x, x2, p3, p5, p7, p9, e;
		longint s;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			x  = (u64_t'(k) << 30) / SINE_DEPTH;
			x2 = (x * x) >> 30;
			p3 = (x * x2) >> 30;
			p5 = (p3 * x2) >> 30;
			p7 = (p5 * x2) >> 30;
			p9 = (p7 * x2) >> 30;
			s = longint'((COEF1 * x) >> 30) + longint'((COEF5 * p5) >> 30)
				+ longint'((COEF9 * p9) >> 30) - longint'((COEF3 * p3) >> 30)
				- longint'((COEF7 * p7) >> 30);
			if (s < 0) begin
				s = 0;
			end
			e = (u64_t'(s) * 64'd32768 + Q30_ONE / 2) >> 30;
			if (e > 64'd32768) begin
				e = 64'd32768;
			end
			t[k] = e[15:0];
		end
		return t;
	endfunction

	localparam rom_t SINE_ROM = sine_rom_f();

endpackage

// File: hdl/pwg_div_cell.sv
// One restoring-division cell: shifts one dividend bit into the remainder per cycle while en is high.
// Depends on pwg_pkg.
module pwg_div_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [31:0]       period,
	input  pwg_pkg::div_word_t d_in,
	output pwg_pkg::div_word_t d_out
);
	import pwg_pkg::*;

	logic [32:0] rem2;
	logic [32:0] diff;
	logic        ge;

	assign rem2 = {d_in.rem, d_in.num[32]};
	assign diff = rem2 - {1'b0, period};
	assign ge   = rem2 >= {1'b0, period};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			d_out <= '0;
		end else if (en) begin
			d_out.valid <= d_in.valid;
			d_out.rem   <= ge ? diff[31:0] : rem2[31:0];
			d_out.num   <= {d_in.num[31:0], 1'b0};
			d_out.quo   <= {d_in.quo[FRAC_BITS-2:0], ge};
			d_out.sq    <= d_in.sq;
		end
	end

endmodule

// File: hdl/pwg_shaper.sv
// Wave shaping back end: sine ROM lookup, linear waves, amplitude scale, offset and saturation.
// Depends on pwg_pkg.
module pwg_shaper (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          en,
	input  logic                          valid,
	input  logic [pwg_pkg::FRAC_BITS-1:0] frac,
	input  logic                          sq,
	input  logic [2:0]                    wave_mode,
	input  logic signed [15:0]            amplitude,
	input  logic signed [15:0]            level_offset,
	output logic                          sample_valid,
	output logic signed [15:0]            sample_value,
	output logic                          clipped
);
	import pwg_pkg::*;

	localparam int PW = FRAC_BITS + IDX_BITS + 1;

	logic [PW-1:0]        sine_full, half_full;
	logic [IDX_BITS:0]    half_sum;
	logic [IDX_BITS-1:0]  idx;
	logic [1:0]           quad;
	logic [ROM_AW-1:0]    kk, addr;
	logic [FRAC_BITS+17:0] u2_full, u4_full;
	logic signed [18:0]   u2, u4, lin;
	logic                 rom_sel;

	logic                 valid_s1, neg_s1, rom_sel_s1;
	logic [ROM_AW-1:0]    addr_s1;
	logic signed [16:0]   lin_s1;
	logic                 valid_s2, neg_s2, rom_sel_s2;
	logic [15:0]          rom_s2;
	logic signed [16:0]   lin_s2, w_s2;
	logic                 valid_s3;
	logic signed [33:0]   prod_s3;
	logic signed [33:0]   rnd;
	logic signed [19:0]   sum;

	always_comb begin
		sine_full = PW'(frac) * PW'(4 * SINE_DEPTH);
		half_full = PW'(frac) * PW'(2 * SINE_DEPTH);
		half_sum  = (IDX_BITS+1)'(half_full >> FRAC_BITS) + (IDX_BITS+1)'(3 * SINE_DEPTH);
		if (wave_mode == WAVE_SINE) begin
			idx = IDX_BITS'(sine_full >> FRAC_BITS);
		end else begin
			idx = IDX_BITS'(half_sum % (4 * SINE_DEPTH));
		end
		quad = 2'(idx / SINE_DEPTH);
		kk   = ROM_AW'(idx % SINE_DEPTH);
		addr = quad[0] ? ROM_AW'(SINE_DEPTH) - kk : kk;

		u2_full = (FRAC_BITS+18)'(frac) << 16;
		u4_full = (FRAC_BITS+18)'(frac) << 17;
		u2 = 19'(u2_full >> FRAC_BITS);
		u4 = 19'(u4_full >> FRAC_BITS);
		rom_sel = 1'b0;
		case (wave_mode) inside
			WAVE_HALF_SINE, WAVE_SINE: begin
				rom_sel = 1'b1;
				lin = '0;
			end
			WAVE_SQUARE:   lin = sq ? 19'sd32768 : -19'sd32768;
			WAVE_SAW:      lin = u2 - 19'sd32768;
			WAVE_TRIANGLE: begin
				if (frac <= FRAC_BITS'(1 << (FRAC_BITS - 1))) begin
					lin = u4 - 19'sd32768;
				end else begin
					lin = 19'sd98304 - u4;
				end
			end
			default:       lin = '0;
		endcase
	end

	assign w_s2 = rom_sel_s2 ? (neg_s2 ? -$signed({1'b0, rom_s2}) : $signed({1'b0, rom_s2}))
		: lin_s2;

	always_comb begin
		rnd = (prod_s3 + 34'sd16384) >>> 15;
		sum = 20'(level_offset) + 20'(rnd);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1     <= 1'b0;
			valid_s2     <= 1'b0;
			valid_s3     <= 1'b0;
			sample_valid <= 1'b0;
		end else if (en) begin
			valid_s1     <= valid;
			valid_s2     <= valid_s1;
			valid_s3     <= valid_s2;
			sample_valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			addr_s1    <= addr;
			neg_s1     <= quad[1];
			rom_sel_s1 <= rom_sel;
			lin_s1     <= 17'(lin);
			rom_s2     <= SINE_ROM[addr_s1];
			neg_s2     <= neg_s1;
			rom_sel_s2 <= rom_sel_s1;
			lin_s2     <= lin_s1;
			prod_s3    <= 34'(amplitude) * 34'(w_s2);
			if (sum > 20'sd32767) begin
				sample_value <= 16'sh7fff;
				clipped      <= 1'b1;
			end else if (sum < -20'sd32768) begin
				sample_value <= 16'sh8000;
				clipped      <= 1'b1;
			end else begin
				sample_value <= sum[15:0];
				clipped      <= 1'b0;
			end
		end
	end

endmodule

// File: hdl/periodic_waveform_generator.sv
// Top level of the periodic waveform generator: configuration registers, division cell chain
// and wave shaper. Depends on pwg_pkg, pwg_div_cell and pwg_shaper.
//
// Usage:
//  - Time channel (time_valid, time_stall, time_tick): one request per time value.
//  - Sample channel (sample_valid, sample_stall, sample_value, clipped): one result per request,
//    in order.
//  - Config channel (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is always high;
//    write only while no request is in flight. Period 0 is stored as 1.
//  - Pipeline: 33 cells form (time + phase) mod period, 16 more cells form the
//    fraction bits, then 4 shaper stages (ROM address, ROM read, multiply, round/saturate).
//  - One sample per clock when not stalled; every division cell handles one bit per cycle.
//  - When the sample side stalls a valid result, the whole chain holds and time_stall rises
//    in the same cycle; nothing is lost.
//  - Reset clears all valid bits and loads sine mode, zero amplitude, offset and phase,
//    and period 1.
module periodic_waveform_generator (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               time_valid,
	output logic               time_stall,
	input  logic [31:0]        time_tick,
	output logic               sample_valid,
	input  logic               sample_stall,
	output logic signed [15:0] sample_value,
	output logic               clipped,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import pwg_pkg::*;

	logic              en;
	logic [2:0]        wave_mode_q;
	logic signed [15:0] amplitude_q, level_offset_q;
	logic [31:0]       phase_shift_q, period_ticks_q;
	div_word_t         link [TOTAL_CELLS+1];
	div_word_t         cell_in [TOTAL_CELLS];
	div_word_t         frac_in;

	assign en         = !(sample_valid && sample_stall);
	assign time_stall = !en;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wave_mode_q    <= WAVE_SINE;
			amplitude_q    <= '0;
			level_offset_q <= '0;
			phase_shift_q  <= '0;
			period_ticks_q <= 32'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_WAVE_MODE:    wave_mode_q    <= cfg_data[2:0];
				REG_AMPLITUDE:    amplitude_q    <= cfg_data[15:0];
				REG_LEVEL_OFFSET: level_offset_q <= cfg_data[15:0];
				REG_PHASE_SHIFT:  phase_shift_q  <= cfg_data;
				REG_PERIOD_TICKS: period_ticks_q <= (cfg_data == '0) ? 32'd1 : cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		link[0].valid = time_valid;
		link[0].rem   = '0;
		link[0].num   = {1'b0, time_tick} + {1'b0, phase_shift_q};
		link[0].quo   = '0;
		link[0].sq    = 1'b0;

		frac_in       = link[MOD_CELLS];
		frac_in.num   = '0;
		frac_in.quo   = '0;
		frac_in.sq    = {link[MOD_CELLS].rem, 1'b0} > {1'b0, period_ticks_q};
	end

	for (genvar i = 0; i < TOTAL_CELLS; i++) begin : g_cell
		if (i == MOD_CELLS) begin : g_frac_start
			assign cell_in[i] = frac_in;
		end else begin : g_chain
			assign cell_in[i] = link[i];
		end
		pwg_div_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.en     (en),
			.period (period_ticks_q),
			.d_in   (cell_in[i]),
			.d_out  (link[i+1])
		);
	end

	pwg_shaper u_shaper (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.valid        (link[TOTAL_CELLS].valid),
		.frac         (link[TOTAL_CELLS].quo),
		.sq           (link[TOTAL_CELLS].sq),
		.wave_mode    (wave_mode_q),
		.amplitude    (amplitude_q),
		.level_offset (level_offset_q),
		.sample_valid (sample_valid),
		.sample_value (sample_value),
		.clipped      (clipped)
	);

	a_period_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		period_ticks_q != '0) else $error("period register is zero");

	a_rem_below_period: assert property (@(posedge clk) disable iff (!arst_n)
		link[MOD_CELLS].valid |-> link[MOD_CELLS].rem < period_ticks_q)
		else $error("modulo remainder not below period");

	a_clip_saturates: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && clipped) |-> (sample_value == 16'sh7fff || sample_value == 16'sh8000))
		else $error("clipped sample not at a rail");

	a_hold_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_stall) |=> $stable(link[TOTAL_CELLS]))
		else $error("chain moved while output stalled");

endmodule

// File: test/tb.sv
// Testbench for periodic_waveform_generator: predicts every sample from the register settings
// and time value, checks results in order under random request gaps and sample stalls.
// Depends on pwg_pkg and the RTL of periodic_waveform_generator.
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pwg_pkg::*;

	typedef struct {
		logic signed [15:0] value;
		logic               clip;
	} sample_t;

	logic               clk;
	logic               arst_n;
	logic               time_valid;
	logic               time_stall;
	logic [31:0]        time_tick;
	logic               sample_valid;
	logic               sample_stall;
	logic signed [15:0] sample_value;
	logic               clipped;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [2:0]         cfg_index;
	logic [31:0]        cfg_data;

	logic [2:0]         m_mode;
	logic signed [15:0] m_amp;
	logic signed [15:0] m_offset;
	logic [31:0]        m_phase;
	logic [31:0]        m_period;
	int                 quarter_wave [SINE_DEPTH+1];

	sample_t            samples_due [$];
	int                 errors;
	int                 n_sent;
	int                 n_seen;
	int                 n_clipped;
	bit                 hold_long;
	int                 stall_pct;

	periodic_waveform_generator DUT (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2ms;
		$display("Timeout with %0d samples outstanding", samples_due.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic int quarter_sine(int k);
		u64_t x, x2, p3, p5, p7, p9, e;
		longint s;
		x  = (u64_t'(k) << 30) / SINE_DEPTH;
		x2 = (x * x) >> 30;
		p3 = (x * x2) >> 30;
		p5 = (p3 * x2) >> 30;
		p7 = (p5 * x2) >> 30;
		p9 = (p7 * x2) >> 30;
		s = longint'((64'd1686629713 * x) >> 30) - longint'((64'd693598669 * p3) >> 30)
			+ longint'((64'd85569306 * p5) >> 30) - longint'((64'd5026995 * p7) >> 30)
			+ longint'((64'd172272 * p9) >> 30);
		if (s < 0) begin
			s = 0;
		end
		e = (u64_t'(s) * 32768 + 64'd536870912) >> 30;
		return (e > 32768) ? 32768 : int'(e);
	endfunction

	function automatic longint full_sine(u64_t idx);
		u64_t k;
		idx = idx % (4 * SINE_DEPTH);
		k = idx % SINE_DEPTH;
		case (idx / SINE_DEPTH)
			0: begin
				return quarter_wave[k];
			end
			1: begin
				return quarter_wave[SINE_DEPTH - k];
			end
			2: begin
				return -quarter_wave[k];
			end
			default: begin
				return -quarter_wave[SINE_DEPTH - k];
			end
		endcase
	endfunction

	function automatic sample_t waveform_sample(logic [31:0] t);
		u64_t p, r, f, u;
		longint w, scaled, sum;
		sample_t res;
		p = m_period;
		r = (u64_t'(t) + m_phase) % p;
		f = (r << FRAC_BITS) / p;
		case (m_mode)
			WAVE_HALF_SINE: begin
				w = full_sine(((f * 2 * SINE_DEPTH) >> FRAC_BITS) + 3 * SINE_DEPTH);
			end
			WAVE_SINE: begin
				w = full_sine((f * 4 * SINE_DEPTH) >> FRAC_BITS);
			end
			WAVE_SQUARE: begin
				w = (2 * r > p) ? 32768 : -32768;
			end
			WAVE_SAW: begin
				w = longint'(((2 * f) << 15) >> FRAC_BITS) - 32768;
			end
			WAVE_TRIANGLE: begin
				u = ((4 * f) << 15) >> FRAC_BITS;
				w = (f <= (64'd1 << (FRAC_BITS - 1))) ? longint'(u) - 32768 : 98304 - longint'(u);
			end
			default: begin
				w = 0;
			end
		endcase
		scaled = (longint'(m_amp) * w + 16384) >>> 15;
		sum = longint'(m_offset) + scaled;
		res.clip = 1'b0;
		if (sum > 32767) begin
			sum = 32767;
			res.clip = 1'b1;
		end else if (sum < -32768) begin
			sum = -32768;
			res.clip = 1'b1;
		end
		res.value = sum[15:0];
		return res;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("Mismatch on sample %0d: %s got %0h, want %0h", n_seen, what, got, want);
	endtask

	// checker
	always @(posedge clk) begin
		sample_t want;
		if (arst_n && sample_valid && !sample_stall) begin
			if (samples_due.size() == 0) begin
				report("unexpected sample", 32'(sample_value), 32'd0);
			end else begin
				want = samples_due.pop_front();
				if (sample_value !== want.value) begin
					report("sample_value", 32'(sample_value), 32'(want.value));
				end
				if (clipped !== want.clip) begin
					report("clipped", 32'(clipped), 32'(want.clip));
				end
				n_clipped += want.clip;
			end
			n_seen++;
		end
	end

	// receiver stall pattern, with a long hold on request
	initial begin
		int i;
		sample_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_long) begin
				sample_stall = 1'b1;
				for (i = 0; i < 300; i++) begin
					@(negedge clk);
				end
				hold_long = 1'b0;
				sample_stall = 1'b0;
			end else begin
				sample_stall = ($urandom_range(99) < stall_pct);
				if ($urandom_range(199) == 0) begin
					stall_pct = $urandom_range(3) * 25;
				end
			end
		end
	end

	task automatic send_time(logic [31:0] t);
		@(negedge clk);
		time_valid = 1'b1;
		time_tick = t;
		do @(posedge clk); while (time_stall);
		samples_due.push_back(waveform_sample(t));
		n_sent++;
	endtask

	task automatic idle(int cycles);
		@(negedge clk);
		time_valid = 1'b0;
		time_tick = $urandom;
		repeat (cycles) @(negedge clk);
	endtask

	task automatic drain();
		idle(0);
		wait (samples_due.size() == 0);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] data);
		drain();
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			REG_WAVE_MODE: begin
				m_mode = data[2:0];
			end
			REG_AMPLITUDE: begin
				m_amp = data[15:0];
			end
			REG_LEVEL_OFFSET: begin
				m_offset = data[15:0];
			end
			REG_PHASE_SHIFT: begin
				m_phase = data;
			end
			REG_PERIOD_TICKS: begin
				m_period = (data == 0) ? 32'd1 : data;
			end
			default: begin
			end
		endcase
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic setup(logic [2:0] mode, logic [31:0] amp, logic [31:0] offs,
			logic [31:0] ph, logic [31:0] per);
		write_reg(REG_WAVE_MODE, mode);
		write_reg(REG_AMPLITUDE, amp);
		write_reg(REG_LEVEL_OFFSET, offs);
		write_reg(REG_PHASE_SHIFT, ph);
		write_reg(REG_PERIOD_TICKS, per);
	endtask

	function automatic logic [31:0] pick_period();
		case ($urandom_range(5))
			0: begin
				return $urandom_range(1, 4);
			end
			1: begin
				return $urandom_range(5, 5000);
			end
			2: begin
				return 32'hFFFF_FFFF - $urandom_range(3);
			end
			3: begin
				return $urandom_range(0, 1) ? 32'd0 : 32'h8000_0000;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	function automatic logic [31:0] pick_level();
		case ($urandom_range(3))
			0: begin
				return $urandom_range(1) ? 32'h0000_7FFF : 32'hFFFF_8000;
			end
			1: begin
				return $urandom_range(1) ? 32'h0000_0000 : 32'h1234_0001;
			end
			default: begin
				return $urandom;
			end
		endcase
	endfunction

	task automatic test_reset_state();
		send_time(32'd0);
		send_time(32'hFFFF_FFFF);
		send_time(32'h5555_AAAA);
	endtask

	task automatic test_each_mode();
		logic [2:0] mode;
		for (int i = 0; i < 8; i++) begin
			mode = i;
			setup(mode, 32'h7FFF, 32'd0, 32'd0, 32'd1000);
			send_time(32'd0);
			send_time(32'd250);
			send_time(32'd500);
		end
		write_reg(REG_WAVE_MODE, WAVE_SQUARE);
		write_reg(REG_PERIOD_TICKS, 32'hFFFF_FFFF);
		write_reg(REG_PHASE_SHIFT, 32'hFFFF_FFFF);
		send_time(32'hFFFF_FFFF);
	endtask

	task automatic test_registers();
		setup(WAVE_TRIANGLE, 32'hABCD_8000, 32'h0001_7FFF, 32'd7, 32'd0);
		send_time(32'd3);
		write_reg(3'd5, 32'hFFFF_FFFF);
		write_reg(3'd6, 32'd0);
		write_reg(3'd7, 32'h1234_5678);
		write_reg(REG_WAVE_MODE, 32'hFFFF_FFFB);
		send_time(32'd1);
		write_reg(REG_PERIOD_TICKS, 32'd4);
		send_time(32'd2);
		send_time(32'd4);
	endtask

	task automatic test_random(int phases, int per_phase);
		int sent;
		for (int ph = 0; ph < phases; ph++) begin
			setup($urandom_range(0, 9) < 9 ? $urandom_range(4) : $urandom_range(5, 7),
				pick_level(), pick_level(),
				$urandom_range(2) == 0 ? 32'hFFFF_FFFF : $urandom, pick_period());
			sent = 0;
			while (sent < per_phase) begin
				repeat ($urandom_range(1, 30)) begin
					if (sent < per_phase) begin
						send_time($urandom_range(3) == 0 ? $urandom_range(m_period + 2) : $urandom);
						sent++;
					end
				end
				if ($urandom_range(2) != 0) begin
					idle($urandom_range(0, 6));
				end
			end
		end
	endtask

	task automatic test_backpressure();
		setup(WAVE_SINE, 32'h7FFF, 32'd100, 32'd0, 32'd4096);
		hold_long = 1'b1;
		repeat (200) send_time($urandom);
		idle(0);
		wait (samples_due.size() == 0);
		repeat (100) send_time($urandom);
	endtask

	initial begin
		arst_n = 1'b0;
		time_valid = 1'b0;
		time_tick = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		hold_long = 1'b0;
		stall_pct = 25;
		errors = 0;
		n_sent = 0;
		n_seen = 0;
		n_clipped = 0;
		m_mode = WAVE_SINE;
		m_amp = '0;
		m_offset = '0;
		m_phase = '0;
		m_period = 32'd1;
		for (int k = 0; k <= SINE_DEPTH; k++) begin
			quarter_wave[k] = quarter_sine(k);
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_state();
		test_each_mode();
		test_registers();
		test_backpressure();
		test_random(10, 120);

		drain();
		$display("Covered %0d requests, %0d samples checked (%0d clipped), all modes and registers",
			n_sent, n_seen, n_clipped);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
